[rtl/core/gfs_pkg.sv]
// Package with field constants and GF(2^8) helper functions for the S-box pipeline.
package gfs_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W:0]   FIELD_POLY   = 9'h1B1;
    localparam logic [BYTE_W-1:0] AFFINE_CONST = 8'h63;

    typedef logic [BYTE_W-1:0] t_byte;

    // Shift-and-add multiply with reduction by the field polynomial.
    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte          acc;
        logic [BYTE_W:0] sh;
        acc = '0;
        sh  = {1'b0, a};
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                acc = acc ^ sh[BYTE_W-1:0];
            end
            sh = {sh[BYTE_W-1:0], 1'b0};
            if (sh[BYTE_W]) begin
                sh = sh ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // Squaring is linear over GF(2), so this collapses to an XOR network.
    function automatic t_byte gf_sq(input t_byte a);
        return gf_mul(a, a);
    endfunction

    function automatic t_byte rotl1(input t_byte v);
        return {v[BYTE_W-2:0], v[BYTE_W-1]};
    endfunction

    function automatic t_byte affine(input t_byte v);
        t_byte r1;
        t_byte r2;
        t_byte r3;
        t_byte r4;
        r1 = rotl1(v);
        r2 = rotl1(r1);
        r3 = rotl1(r2);
        r4 = rotl1(r3);
        return v ^ r1 ^ r2 ^ r3 ^ r4 ^ AFFINE_CONST;
    endfunction

endpackage

[rtl/core/gfs_inv_pipe.sv]
// Three-stage pipeline that raises a byte to the 254th power in GF(2^8).
module gfs_inv_pipe (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  gfs_pkg::t_byte i_byte,
    output logic         o_valid,
    input  logic         i_ready,
    output gfs_pkg::t_byte o_inv
);
    import gfs_pkg::*;

    // a^254 = a^2 * a^4 * a^8 * a^16 * a^32 * a^64 * a^128
    t_byte a2, a4, a8, a16, a32, a64, a128;

    logic  r_v1, r_v2, r_v3;
    t_byte r_m1, r_m2, r_m3, r_a128;
    t_byte r_q1, r_q2;
    t_byte r_inv;

    logic adv1, adv2, adv3;

    assign adv3 = !r_v3 || i_ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_ready = adv1;
    assign o_valid = r_v3;
    assign o_inv   = r_inv;

    always_comb begin
        a2   = gf_sq(i_byte);
        a4   = gf_sq(a2);
        a8   = gf_sq(a4);
        a16  = gf_sq(a8);
        a32  = gf_sq(a16);
        a64  = gf_sq(a32);
        a128 = gf_sq(a64);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload moves with its valid bit; a stalled stage holds.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_m1   <= gf_mul(a2, a4);
            r_m2   <= gf_mul(a8, a16);
            r_m3   <= gf_mul(a32, a64);
            r_a128 <= a128;
        end
        if (adv2) begin
            r_q1 <= gf_mul(r_m1, r_m2);
            r_q2 <= gf_mul(r_m3, r_a128);
        end
        if (adv3) begin
            r_inv <= gf_mul(r_q1, r_q2);
        end
    end

endmodule

[rtl/core/gf256_inverse_affine_sbox_unit.sv]
// Top level of the byte substitution box: field inverse then affine transform.
//
// Usage:
//   Input request channel i_valid / o_ready carries i_in_byte; result channel
//   o_valid / i_ready carries o_out_byte. A request is taken on a clock edge
//   where valid and ready are both high.
//   Each byte leaves as the affine transform of its inverse in GF(2^8) over
//   the polynomial 0x1B1; zero maps to 0x63.
//   Four register stages: three multiply stages forming a^254, then one
//   registered affine stage at the output, which drives o_valid and
//   o_out_byte. Throughput is one byte per cycle while the receiver
//   keeps i_ready high.
//   When the receiver drops i_ready, stages hold their data and empty
//   stages further up keep filling, so up to four requests are taken before
//   o_ready falls. Nothing is lost or repeated across a stall.
//   Synchronous active-low reset i_rst_n empties the pipeline; there is no
//   other state.
module gf256_inverse_affine_sbox_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_in_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte
);
    import gfs_pkg::*;

    logic  inv_valid;
    logic  inv_ready;
    t_byte inv_byte;

    logic  r_v4;
    t_byte r_out;

    gfs_inv_pipe u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_in_byte),
        .o_valid (inv_valid),
        .i_ready (inv_ready),
        .o_inv   (inv_byte)
    );

    assign inv_ready = !r_v4 || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (inv_ready) begin
            r_v4 <= inv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (inv_ready) begin
            r_out <= affine(inv_byte);
        end
    end

    assign o_valid    = r_v4;
    assign o_out_byte = r_out;

endmodule

[bench/testbench.sv]
// Self-checking bench for the GF(2^8) inverse plus affine byte substitution unit.
`timescale 1ns / 1ps

module testbench;

    localparam logic [8:0] REDUCE_POLY    = 9'h1B1;
    localparam logic [7:0] AFFINE_OFFSET  = 8'h63;
    localparam int         PIPE_LATENCY   = 4;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_BYTES   = 900;
    localparam int         STREAM_BYTES   = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;

    logic [7:0] pending_subst[$];
    int         bytes_sent;
    int         results_checked;
    int         mismatch_count;
    int         quiet_cycles;
    bit         send_gaps;
    bit         rx_stalls;

    gf256_inverse_affine_sbox_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] shifted;
        logic [7:0] acc;
        shifted = {1'b0, a};
        acc     = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc ^= shifted[7:0];
            end
            shifted = shifted << 1;
            if (shifted[8]) begin
                shifted ^= REDUCE_POLY;
            end
        end
        return acc;
    endfunction

    // Search for the partner whose product is one; zero has none and stays zero.
    function automatic logic [7:0] field_reciprocal(input logic [7:0] a);
        logic [7:0] found;
        found = '0;
        for (int cand = 1; cand < 256; cand++) begin
            if (field_product(a, cand[7:0]) == 8'h01) begin
                found = cand[7:0];
            end
        end
        return found;
    endfunction

    function automatic logic [7:0] substitute_byte(input logic [7:0] a);
        logic [7:0] inv;
        logic [7:0] res;
        inv = field_reciprocal(a);
        for (int k = 0; k < 8; k++) begin
            res[k] = inv[k] ^ inv[(k + 4) % 8] ^ inv[(k + 5) % 8]
                   ^ inv[(k + 6) % 8] ^ inv[(k + 7) % 8] ^ AFFINE_OFFSET[k];
        end
        return res;
    endfunction

    // Record each accepted request, check each delivered result, watch for a hang.
    always @(posedge i_clk) begin : scoreboard
        logic [7:0] want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                pending_subst = {pending_subst, substitute_byte(i_in_byte)};
            end
            if (o_valid && i_ready) begin
                if (pending_subst.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %02h",
                             $realtime, o_out_byte);
                    mismatch_count++;
                end else begin
                    want = pending_subst.pop_front();
                    results_checked++;
                    if (o_out_byte !== want) begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $realtime, want, o_out_byte);
                        mismatch_count++;
                    end
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, pending_subst.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: stall in bursts while enabled, otherwise always ready.
    always begin : result_sink
        int hold;
        @(negedge i_clk);
        if (rx_stalls && $urandom_range(0, 3) == 0) begin
            hold = $urandom_range(1, 4);
            i_ready <= 1'b0;
            repeat (hold) @(negedge i_clk);
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Returns at the rising edge where the request is taken.
    task automatic send_byte(input logic [7:0] value);
        int hold;
        @(negedge i_clk);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            hold = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (hold) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= value;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic release_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain_results();
        release_valid();
        while (pending_subst.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [7:0] corner[$];
        send_gaps = 1'b0;
        rx_stalls = 1'b0;
        corner = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE, 8'h02};
        foreach (corner[k]) send_byte(corner[k]);
        for (int k = 0; k < 8; k++) begin
            send_byte(8'h01 << k);
        end
        drain_results();
    endtask

    task automatic test_exhaustive();
        send_gaps = 1'b1;
        rx_stalls = 1'b1;
        for (int v = 0; v < 256; v++) begin
            send_byte(v[7:0]);
        end
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_BYTES; n++) begin
            // reshuffle idling every so often so quiet stretches appear too
            if (n % 64 == 0) begin
                send_gaps = 1'($urandom_range(0, 1));
                rx_stalls = 1'($urandom_range(0, 1));
            end
            if (n == RANDOM_BYTES / 2) begin
                drain_results();
            end
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_streaming();
        send_gaps = 1'b0;
        rx_stalls = 1'b0;
        for (int n = 0; n < STREAM_BYTES; n++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_in_byte       = '0;
        i_ready         = 1'b0;
        send_gaps       = 1'b0;
        rx_stalls       = 1'b0;
        bytes_sent      = 0;
        results_checked = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_exhaustive();
        test_random_traffic();
        test_streaming();

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("Sent %0d bytes: corner values, all 256 codes, random traffic with a drain pause",
                 bytes_sent);
        $display("Compared %0d results under sender gaps and receiver stalls, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
